[design/set_assoc_cache_tree_plru_assert.svh]
// assertion macros for the checker file of the cache directory
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef SET_ASSOC_CACHE_TREE_PLRU_ASSERT_SVH
`define SET_ASSOC_CACHE_TREE_PLRU_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SACP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SACP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// expression never holds
`define SACP_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

[design/sacp_pkg.sv]
// shared types and constants of the tree plru cache directory
// no dependencies
package sacp_pkg;

    localparam int DEF_SETS  = 8;
    localparam int DEF_WAYS  = 8;
    localparam int ADDR_W    = 32;
    localparam int WAY_OUT_W = 3;

    // request kinds
    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_INVAL  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_INDEX  = 4'b0100,
        ST_UPDATE = 4'b1000
    } sacp_state_t;

    // outcome of one set lookup
    typedef struct packed {
        logic hit;
        logic fill;
    } sacp_ctl_t;

endpackage

[design/sacp_set_index.sv]
// set index unit: address modulo the set count
// depends on sacp_pkg; mask for a power-of-two set count, else reciprocal pipeline
module sacp_set_index #(
    parameter int SETS = sacp_pkg::DEF_SETS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [sacp_pkg::ADDR_W-1:0]   address,
    output logic                          done,
    output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] set_idx
);

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;

    generate
        if ((SETS & (SETS - 1)) == 0) begin : g_mask
            // low bits of the address
            assign done = start;
            if (SETS > 1) begin : g_bits
                assign set_idx = address[SET_W-1:0];
            end else begin : g_zero
                assign set_idx = '0;
            end
        end else begin : g_recip
            localparam int L = $clog2(SETS);
            localparam int Q_W = 33 - L;
            localparam logic [63:0] RECIP = (64'd1 << (32 + L)) / 64'(SETS);

            logic [64:0]                  prod;
            logic [Q_W-1:0]               quot_reg;
            logic [sacp_pkg::ADDR_W-1:0]  addr_reg;
            logic [sacp_pkg::ADDR_W-1:0]  rem_full;
            logic [SET_W:0]               rem_reg;
            logic [SET_W-1:0]             set_reg;
            logic [2:0]                   stage_reg;

            // quotient estimate, low by at most one
            assign prod = 65'(address) * 65'(RECIP[32:0]);
            assign rem_full = addr_reg - sacp_pkg::ADDR_W'(quot_reg * sacp_pkg::ADDR_W'(SETS));

            always_ff @(posedge aclk) begin
                quot_reg <= prod[32+L +: Q_W];
                addr_reg <= address;
                rem_reg  <= rem_full[SET_W:0];
                if (rem_reg >= (SET_W+1)'(SETS)) begin
                    set_reg <= SET_W'(rem_reg - (SET_W+1)'(SETS));
                end else begin
                    set_reg <= rem_reg[SET_W-1:0];
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    stage_reg <= '0;
                end else begin
                    stage_reg <= {stage_reg[1:0], start};
                end
            end

            assign done    = stage_reg[2];
            assign set_idx = set_reg;
        end
    endgenerate

endmodule

[design/sacp_way_logic.sv]
// way compare, tree plru victim walk and hit update for one set
// depends on sacp_pkg
module sacp_way_logic #(
    parameter int WAYS = sacp_pkg::DEF_WAYS
) (
    input  logic                              kind,
    input  logic [sacp_pkg::ADDR_W-1:0]       address,
    input  logic [WAYS*sacp_pkg::ADDR_W-1:0]  row_addr,
    input  logic [WAYS-1:0]                   row_valid,
    input  logic [WAYS-2:0]                   row_tree,
    output sacp_pkg::sacp_ctl_t               ctl,
    output logic [$clog2(WAYS)-1:0]           way,
    output logic [WAYS-1:0]                   new_valid,
    output logic [WAYS-2:0]                   new_tree
);

    localparam int WAY_W  = $clog2(WAYS);
    localparam int TREE_W = WAYS - 1;
    localparam int DEPTH  = $clog2(WAYS);
    localparam int NODE_W = $clog2(2 * WAYS - 1);
    localparam int TI_W   = (TREE_W > 1) ? $clog2(TREE_W) : 1;

    logic [WAYS-1:0]   match;
    logic              match_any;
    logic [WAY_W-1:0]  match_way;
    logic [WAY_W-1:0]  victim_way;
    logic [TREE_W-1:0] tree_walk;
    logic [TREE_W-1:0] tree_touch;
    logic [NODE_W-1:0] walk_node;
    logic [NODE_W-1:0] touch_node;
    logic [NODE_W-1:0] touch_parent;

    // valid matches, lowest way wins
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            match[w] = row_valid[w] &&
                       (row_addr[w*sacp_pkg::ADDR_W +: sacp_pkg::ADDR_W] == address);
        end
        match_any = |match;
        match_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                match_way = WAY_W'(w);
            end
        end
    end

    // victim walk from the root, toggling each node passed
    always_comb begin
        walk_node = '0;
        tree_walk = row_tree;
        for (int lvl = 0; lvl < DEPTH; lvl++) begin
            if (walk_node < NODE_W'(TREE_W)) begin
                if (tree_walk[walk_node[TI_W-1:0]]) begin
                    tree_walk[walk_node[TI_W-1:0]] = 1'b0;
                    walk_node = (walk_node << 1) + NODE_W'(2);
                end else begin
                    tree_walk[walk_node[TI_W-1:0]] = 1'b1;
                    walk_node = (walk_node << 1) + NODE_W'(1);
                end
            end
        end
        victim_way = WAY_W'(walk_node - NODE_W'(TREE_W));
    end

    // hit update: every node on the path points away from the hit leaf
    always_comb begin
        touch_node   = NODE_W'(TREE_W) + NODE_W'(match_way);
        touch_parent = '0;
        tree_touch   = row_tree;
        for (int lvl = 0; lvl < DEPTH; lvl++) begin
            if (touch_node != '0) begin
                touch_parent = (touch_node - NODE_W'(1)) >> 1;
                tree_touch[touch_parent[TI_W-1:0]] = touch_node[0];
                touch_node = touch_parent;
            end
        end
    end

    always_comb begin
        ctl       = '0;
        way       = match_way;
        new_valid = row_valid;
        new_tree  = row_tree;
        if (kind == sacp_pkg::KIND_ACCESS) begin
            if (match_any) begin
                ctl.hit  = 1'b1;
                new_tree = tree_touch;
            end else begin
                ctl.fill              = 1'b1;
                way                   = victim_way;
                new_tree              = tree_walk;
                new_valid[victim_way] = 1'b1;
            end
        end else begin
            if (match_any) begin
                ctl.hit              = 1'b1;
                new_valid[match_way] = 1'b0;
            end else begin
                way = '0;
            end
        end
    end

endmodule

[design/set_assoc_cache_tree_plru.sv]
// top level of the set-associative cache directory with tree plru replacement
// depends on sacp_pkg, sacp_set_index and sacp_way_logic
//
// Directory of SETS sets by WAYS ways; each way keeps a full 32-bit address and
// a valid bit, each set keeps WAYS-1 tree bits. A request (s_kind, s_address)
// either looks up the address (hit: tree bits along the path point away from
// the way; miss: the tree walk picks and fills a victim) or invalidates a
// matching valid way. Every request gives exactly one result (m_hit, m_way),
// m_way being the low three bits of the way number. The addresses live in one
// synchronous memory of SETS rows, valid and tree bits in a second one. After
// reset a clearing pass writes zero into every valid/tree row, row by row, with
// s_ready low. Requests are handled one at a time: for a power-of-two SETS the
// set row is read, then compared, updated and written back; any other SETS
// first passes the address through the remainder pipeline. The result sits in
// an output register, so the next request is taken while it waits.
module set_assoc_cache_tree_plru #(
    parameter int SETS = sacp_pkg::DEF_SETS,
    parameter int WAYS = sacp_pkg::DEF_WAYS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_kind,
    input  logic [sacp_pkg::ADDR_W-1:0]      s_address,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_hit,
    output logic [sacp_pkg::WAY_OUT_W-1:0]   m_way
);

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = $clog2(WAYS);
    localparam int TREE_W = WAYS - 1;
    localparam int ROW_W  = WAYS * sacp_pkg::ADDR_W;
    localparam int META_W = TREE_W + WAYS;

    // memories: address rows and {tree, valid} rows, one row per set
    logic [ROW_W-1:0]  addr_mem [SETS];
    logic [META_W-1:0] meta_mem [SETS];

    sacp_pkg::sacp_state_t state_reg, state_next;

    logic [SET_W-1:0]              clr_cnt_reg;
    logic [SET_W-1:0]              cur_set_reg;
    logic                          req_kind_reg;
    logic [sacp_pkg::ADDR_W-1:0]   req_addr_reg;
    logic [ROW_W-1:0]              addr_row_reg;
    logic [META_W-1:0]             meta_row_reg;
    logic                          m_valid_reg;
    logic                          m_hit_reg;
    logic [sacp_pkg::WAY_OUT_W-1:0] m_way_reg;

    logic                  req_take;
    logic                  idx_done;
    logic [SET_W-1:0]      idx_set;
    logic                  update_go;
    logic                  addr_we;
    logic                  meta_we;
    logic [SET_W-1:0]      meta_wr_set;
    logic [META_W-1:0]     meta_wr_data;
    logic [ROW_W-1:0]      addr_row_next;

    sacp_pkg::sacp_ctl_t   upd_ctl;
    logic [WAY_W-1:0]      upd_way;
    logic [WAYS-1:0]       upd_valid;
    logic [TREE_W-1:0]     upd_tree;

    assign s_ready  = (state_reg == sacp_pkg::ST_IDLE);
    assign req_take = s_valid && s_ready;

    // set index: address modulo SETS
    sacp_set_index #(
        .SETS (SETS)
    ) u_set_index (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (req_take),
        .address (s_address),
        .done    (idx_done),
        .set_idx (idx_set)
    );

    // compare and replacement on the registered set row
    sacp_way_logic #(
        .WAYS (WAYS)
    ) u_way_logic (
        .kind      (req_kind_reg),
        .address   (req_addr_reg),
        .row_addr  (addr_row_reg),
        .row_valid (meta_row_reg[WAYS-1:0]),
        .row_tree  (meta_row_reg[META_W-1:WAYS]),
        .ctl       (upd_ctl),
        .way       (upd_way),
        .new_valid (upd_valid),
        .new_tree  (upd_tree)
    );

    // write back once the output register can take the result
    assign update_go = (state_reg == sacp_pkg::ST_UPDATE) && (!m_valid_reg || m_ready);
    assign addr_we   = update_go && upd_ctl.fill;
    assign meta_we   = update_go || (state_reg == sacp_pkg::ST_CLEAR);
    assign meta_wr_set  = (state_reg == sacp_pkg::ST_CLEAR) ? clr_cnt_reg : cur_set_reg;
    assign meta_wr_data = (state_reg == sacp_pkg::ST_CLEAR) ? '0 : {upd_tree, upd_valid};

    // fill replaces the victim's address slot in the row
    always_comb begin
        addr_row_next = addr_row_reg;
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == upd_way) begin
                addr_row_next[w*sacp_pkg::ADDR_W +: sacp_pkg::ADDR_W] = req_addr_reg;
            end
        end
    end

    // memory ports: one registered read, one write each; the single request in
    // flight finishes its write before the next read, so no overlap on a row
    always_ff @(posedge aclk) begin
        if (idx_done) begin
            addr_row_reg <= addr_mem[idx_set];
            meta_row_reg <= meta_mem[idx_set];
        end
        if (addr_we) begin
            addr_mem[cur_set_reg] <= addr_row_next;
        end
        if (meta_we) begin
            meta_mem[meta_wr_set] <= meta_wr_data;
        end
    end

    // request fields and set of the row being worked on
    always_ff @(posedge aclk) begin
        if (req_take) begin
            req_kind_reg <= s_kind;
            req_addr_reg <= s_address;
        end
        if (idx_done) begin
            cur_set_reg <= idx_set;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sacp_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == SET_W'(SETS - 1)) begin
                    state_next = sacp_pkg::ST_IDLE;
                end
            end
            sacp_pkg::ST_IDLE: begin
                if (req_take) begin
                    state_next = idx_done ? sacp_pkg::ST_UPDATE : sacp_pkg::ST_INDEX;
                end
            end
            sacp_pkg::ST_INDEX: begin
                if (idx_done) begin
                    state_next = sacp_pkg::ST_UPDATE;
                end
            end
            sacp_pkg::ST_UPDATE: begin
                if (update_go) begin
                    state_next = sacp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sacp_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sacp_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == sacp_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (update_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (update_go) begin
            m_hit_reg <= upd_ctl.hit;
            m_way_reg <= sacp_pkg::WAY_OUT_W'(upd_way);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hit   = m_hit_reg;
    assign m_way   = m_way_reg;

endmodule

[design/sacp_checker.sv]
// port-level checker for the cache directory, bound to the top level
// depends on set_assoc_cache_tree_plru_assert.svh and sacp_pkg
`include "set_assoc_cache_tree_plru_assert.svh"

module sacp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_kind,
    input logic [sacp_pkg::ADDR_W-1:0]     s_address,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_hit,
    input logic [sacp_pkg::WAY_OUT_W-1:0]  m_way
);

    logic [1:0] pend_reg;
    logic       s_take;
    logic       m_take;

    assign s_take = s_valid && s_ready;
    assign m_take = m_valid && m_ready;

    // requests taken but not yet answered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + 2'(s_take) - 2'(m_take);
        end
    end

    `SACP_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_kind) && $stable(s_address), "request changed while waiting")
    `SACP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_hit) && $stable(m_way), "result changed while stalled")
    `SACP_ASSERT_NEVER(a_no_orphan, aclk, aresetn, m_valid && (pend_reg == 2'd0), "result without a pending request")
    `SACP_ASSERT_SAME(a_pend_bound, aclk, aresetn, 1'b1, (pend_reg <= 2'd2) && !(s_ready && pend_reg == 2'd2 && !m_take), "more than two requests in flight")
    `SACP_ASSERT_NEXT(a_one_at_once, aclk, aresetn, s_take, !s_ready, "request taken while another is in the set pipeline")

endmodule

bind set_assoc_cache_tree_plru sacp_checker u_sacp_checker (.*);
